[design/kmc_pkg.sv]
// Shared types, constants and helper functions of the 2-D k-means clustering unit.
// Used by kmeans_2d_clustering_unit; depends on nothing else.
`timescale 1ns / 1ps

package kmc_pkg;

  localparam int COORD_W        = 32;
  localparam int MAX_CLUSTERS   = 16;
  localparam int CIDX_W         = 4;
  localparam int K_W            = 5;
  localparam int ITER_W         = 16;
  localparam int SEED_W         = 32;
  localparam int PADDR_W        = 4;
  localparam int PDATA_W        = 32;
  localparam int MAX_POINTS_DEF = 4096;
  localparam int TOL_LSB        = 6554;
  localparam logic [SEED_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [K_W-1:0]    K_RESET    = 5'd4;
  localparam logic [ITER_W-1:0] ITER_RESET = 16'd100;
  localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

  typedef enum logic [1:0] {
    REG_NUM_CENTROIDS = 2'd0,
    REG_MAX_ITER      = 2'd1,
    REG_SEED          = 2'd2
  } reg_idx_e;

  typedef enum logic [4:0] {
    S_LOAD,
    S_START,
    S_INIT_RD,
    S_INIT_WR,
    S_CHECK,
    S_DECIDE,
    S_A_RD,
    S_A_LD,
    S_D0,
    S_D1,
    S_D2,
    S_D3,
    S_ACC,
    S_U_SEL,
    S_U_DIVX,
    S_U_DIVY,
    S_U_SEED,
    S_U_MOD,
    S_U_RD,
    S_U_WR,
    S_OUT
  } state_e;

  // One step of the 32-bit Galois LFSR that shifts right.
  function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] v);
    logic [SEED_W-1:0] n;
    n = v >> 1;
    if (v[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

[design/kmeans_2d_clustering_unit.sv]
// Top level of the 2-D Lloyd k-means clustering unit: point store, sequencer and shared units.
// Depends on kmc_pkg.
`timescale 1ns / 1ps

// Usage: points enter on the input channel (point_x_i, point_y_i, last_point_i) one per cycle
// while the unit is loading. A transaction with last_point_i set closes the data set and starts
// clustering; in_stall_o then stays high until the final result has entered the output register.
// The configuration port sets K, the iteration limit and the LFSR seed; write it only when idle.
// Each run emits K result transactions, one per centroid, last_result_o set on the final one.
// Clustering runs a setup pass that loads the first K points as centroids, then per iteration
// a convergence check over the K centroids, an assignment of all N points through the
// single shared multiplier, and per cluster a mean in the shared restoring divider of SUM_W
// bits, or a reseed for an empty cluster (SUM_W = 32 + bits of the
// point count, 45 for 4096 points).
// Results then leave at one per cycle while the receiver does not stall; a stalled result
// holds in the output register and the sequencer waits. After the last result the point
// count returns to zero and loading resumes. Reset clears the control state and loads the
// register defaults (K = 4, limit 100, seed 1); the point store needs no clearing pass.
module kmeans_2d_clustering_unit #(
  parameter int MAX_POINTS = kmc_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [kmc_pkg::PADDR_W-1:0]        paddr,
  input  logic [kmc_pkg::PDATA_W-1:0]        pwdata,
  output logic [kmc_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [kmc_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [kmc_pkg::COORD_W-1:0] point_y_i,
  input  logic                               last_point_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [kmc_pkg::CIDX_W-1:0]         centroid_index_o,
  output logic signed [kmc_pkg::COORD_W-1:0] centroid_x_o,
  output logic signed [kmc_pkg::COORD_W-1:0] centroid_y_o,
  output logic [kmc_pkg::ITER_W-1:0]         iterations_used_o,
  output logic                               converged_o,
  output logic                               last_result_o,
  output logic                               too_few_points_o
);
  import kmc_pkg::*;

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = COORD_W + CNT_W;
  localparam int DIV_W  = SUM_W;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int SQ_W   = 2 * COORD_W;
  localparam int DIST_W = SQ_W + 1;

  state_e state_q, state_d;

  logic [K_W-1:0]    cfg_k_q;
  logic [ITER_W-1:0] cfg_iter_q;
  logic [SEED_W-1:0] cfg_seed_q;

  logic [CNT_W-1:0]  cnt_q;
  logic [K_W-1:0]    k_q;
  logic [CIDX_W-1:0] j_q;
  logic [CNT_W-1:0]  i_q;
  logic [ITER_W-1:0] iter_q;
  logic              conv_q;
  logic              few_q;
  logic              close_q;
  logic [SEED_W-1:0] lfsr_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic              out_valid_q;

  logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
  logic signed [COORD_W-1:0] mem_y [MAX_POINTS];
  logic signed [COORD_W-1:0] rd_x_q, rd_y_q;
  logic [ADDR_W-1:0]         raddr;
  logic                      mem_we;

  logic signed [COORD_W-1:0] cen_x [MAX_CLUSTERS];
  logic signed [COORD_W-1:0] cen_y [MAX_CLUSTERS];
  logic signed [COORD_W-1:0] prev_x [MAX_CLUSTERS];
  logic signed [COORD_W-1:0] prev_y [MAX_CLUSTERS];
  logic signed [SUM_W-1:0]   sum_x [MAX_CLUSTERS];
  logic signed [SUM_W-1:0]   sum_y [MAX_CLUSTERS];
  logic [CNT_W-1:0]          mcnt [MAX_CLUSTERS];

  logic signed [COORD_W-1:0] px_q, py_q;
  logic [COORD_W-1:0]        dx_q, dy_q;
  logic [SQ_W-1:0]           sqx_q, sqy_q;
  logic [CIDX_W-1:0]         best_q;
  logic [DIST_W-1:0]         bestd_q;

  logic [CNT_W-1:0] drem_q;
  logic [DIV_W-1:0] dquo_q;
  logic [CNT_W-1:0] ddiv_q;
  logic             dneg_q;

  logic [CIDX_W-1:0]         oidx_q;
  logic signed [COORD_W-1:0] ox_q, oy_q;
  logic [ITER_W-1:0]         oiter_q;
  logic                      oconv_q, olast_q, ofew_q;

  logic              cfg_we, in_acc, load_ok, j_last, i_last, few_c, div_done, dge;
  logic [K_W-1:0]    k_c;
  logic [CNT_W:0]    dtrial, dsub;
  logic [COORD_W-1:0] quo_c, mean_c;
  logic [COORD_W-1:0] mul_a;
  logic [SQ_W-1:0]    prod;
  logic [DIST_W-1:0]  dist_c;
  logic signed [COORD_W:0] wdx, wdy, tdx, tdy;
  logic [COORD_W-1:0] adx, ady, atx, aty;
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]   sum_mag;
  logic [SEED_W-1:0]  lfsr_n;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign in_acc = in_valid_i && !in_stall_o;
  assign load_ok = !out_valid_q || !out_stall_i;

  always_comb begin
    k_c = cfg_k_q;
    if (cfg_k_q == '0) begin
      k_c = K_W'(1);
    end else if (32'(cfg_k_q) > MAX_CLUSTERS) begin
      k_c = K_W'(MAX_CLUSTERS);
    end
  end

  assign j_last = ({1'b0, j_q} == (k_q - K_W'(1)));
  assign i_last = (i_q == (cnt_q - CNT_W'(1)));
  assign few_c  = (32'(cnt_q) < 32'(k_q));
  assign lfsr_n = lfsr_next(lfsr_q);

  // Restoring divider step: one quotient bit per cycle.
  assign div_done = (dcnt_q == '0);
  assign dtrial   = {drem_q, dquo_q[DIV_W-1]};
  assign dge      = (dtrial >= {1'b0, ddiv_q});
  assign dsub     = dtrial - {1'b0, ddiv_q};
  assign quo_c    = dquo_q[COORD_W-1:0];
  assign mean_c   = dneg_q ? (~quo_c + COORD_W'(1)) : quo_c;

  assign sum_sel = (state_q == S_U_SEL) ? sum_x[j_q] : sum_y[j_q];
  assign sum_mag = sum_sel[SUM_W-1] ? (~sum_sel + SUM_W'(1)) : sum_sel;

  assign mul_a  = (state_q == S_D1) ? dx_q : dy_q;
  assign prod   = SQ_W'(mul_a) * SQ_W'(mul_a);
  assign dist_c = {1'b0, sqx_q} + {1'b0, sqy_q};

  assign wdx = {px_q[COORD_W-1], px_q} - {prev_x[j_q][COORD_W-1], prev_x[j_q]};
  assign wdy = {py_q[COORD_W-1], py_q} - {prev_y[j_q][COORD_W-1], prev_y[j_q]};
  assign adx = wdx[COORD_W] ? COORD_W'(-wdx) : wdx[COORD_W-1:0];
  assign ady = wdy[COORD_W] ? COORD_W'(-wdy) : wdy[COORD_W-1:0];
  assign tdx = {cen_x[j_q][COORD_W-1], cen_x[j_q]} - {prev_x[j_q][COORD_W-1], prev_x[j_q]};
  assign tdy = {cen_y[j_q][COORD_W-1], cen_y[j_q]} - {prev_y[j_q][COORD_W-1], prev_y[j_q]};
  assign atx = tdx[COORD_W] ? COORD_W'(-tdx) : tdx[COORD_W-1:0];
  assign aty = tdy[COORD_W] ? COORD_W'(-tdy) : tdy[COORD_W-1:0];

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_NUM_CENTROIDS: prdata = PDATA_W'(cfg_k_q);
      REG_MAX_ITER:      prdata = PDATA_W'(cfg_iter_q);
      REG_SEED:          prdata = PDATA_W'(cfg_seed_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    raddr      = i_q[ADDR_W-1:0];
    unique case (state_q)
      S_LOAD: begin
        in_stall_o = 1'b0;
        mem_we     = in_valid_i && (32'(cnt_q) < MAX_POINTS);
        if (in_valid_i && last_point_i) begin
          state_d = S_START;
        end
      end
      S_START:   state_d = few_c ? S_OUT : S_INIT_RD;
      S_INIT_RD: begin
        raddr   = ADDR_W'(j_q);
        state_d = S_INIT_WR;
      end
      S_INIT_WR: state_d = j_last ? S_CHECK : S_INIT_RD;
      S_CHECK:   state_d = j_last ? S_DECIDE : S_CHECK;
      S_DECIDE: begin
        if (close_q || iter_q >= cfg_iter_q) begin
          state_d = S_OUT;
        end else begin
          state_d = S_A_RD;
        end
      end
      S_A_RD:   state_d = S_A_LD;
      S_A_LD:   state_d = S_D0;
      S_D0:     state_d = S_D1;
      S_D1:     state_d = S_D2;
      S_D2:     state_d = S_D3;
      S_D3:     state_d = j_last ? S_ACC : S_D0;
      S_ACC:    state_d = i_last ? S_U_SEL : S_A_RD;
      S_U_SEL:  state_d = (mcnt[j_q] != '0) ? S_U_DIVX : S_U_SEED;
      S_U_DIVX: state_d = div_done ? S_U_DIVY : S_U_DIVX;
      S_U_DIVY: begin
        if (div_done) begin
          state_d = j_last ? S_CHECK : S_U_SEL;
        end
      end
      S_U_SEED: state_d = S_U_MOD;
      S_U_MOD:  state_d = div_done ? S_U_RD : S_U_MOD;
      S_U_RD: begin
        raddr   = drem_q[ADDR_W-1:0];
        state_d = S_U_WR;
      end
      S_U_WR:   state_d = j_last ? S_CHECK : S_U_SEL;
      S_OUT: begin
        if (load_ok && j_last) begin
          state_d = S_LOAD;
        end
      end
      default:  state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[cnt_q[ADDR_W-1:0]] <= point_x_i;
      mem_y[cnt_q[ADDR_W-1:0]] <= point_y_i;
    end
    rd_x_q <= mem_x[raddr];
    rd_y_q <= mem_y[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_k_q     <= K_RESET;
      cfg_iter_q  <= ITER_RESET;
      cfg_seed_q  <= SEED_RESET;
      cnt_q       <= '0;
      k_q         <= K_W'(1);
      j_q         <= '0;
      i_q         <= '0;
      iter_q      <= '0;
      conv_q      <= 1'b0;
      few_q       <= 1'b0;
      close_q     <= 1'b1;
      lfsr_q      <= SEED_RESET;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_e'(paddr[3:2]))
          REG_NUM_CENTROIDS: cfg_k_q    <= pwdata[K_W-1:0];
          REG_MAX_ITER:      cfg_iter_q <= pwdata[ITER_W-1:0];
          REG_SEED:          cfg_seed_q <= pwdata[SEED_W-1:0];
          default:           cfg_k_q    <= cfg_k_q;
        endcase
      end
      if (state_q == S_OUT && load_ok) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (32'(cnt_q) < MAX_POINTS) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
            if (last_point_i) begin
              k_q <= k_c;
            end
          end
        end
        S_START: begin
          few_q  <= few_c;
          iter_q <= '0;
          conv_q <= 1'b0;
          j_q    <= '0;
          lfsr_q <= (cfg_seed_q != '0) ? cfg_seed_q : SEED_RESET;
        end
        S_INIT_WR: begin
          j_q     <= j_last ? '0 : j_q + CIDX_W'(1);
          close_q <= 1'b1;
        end
        S_CHECK: begin
          close_q <= close_q && (atx < COORD_W'(TOL_LSB)) && (aty < COORD_W'(TOL_LSB));
          j_q     <= j_last ? '0 : j_q + CIDX_W'(1);
        end
        S_DECIDE: begin
          j_q <= '0;
          i_q <= '0;
          if (close_q) begin
            conv_q <= 1'b1;
          end else if (iter_q < cfg_iter_q) begin
            iter_q <= iter_q + ITER_W'(1);
          end
        end
        S_A_LD: j_q <= '0;
        S_D3: begin
          if (!j_last) begin
            j_q <= j_q + CIDX_W'(1);
          end
        end
        S_ACC: begin
          j_q <= '0;
          i_q <= i_last ? '0 : i_q + CNT_W'(1);
        end
        S_U_SEL: begin
          dcnt_q <= DCNT_W'(DIV_W);
          if (mcnt[j_q] == '0) begin
            lfsr_q <= lfsr_n;
          end
        end
        S_U_DIVX: dcnt_q <= div_done ? DCNT_W'(DIV_W) : dcnt_q - DCNT_W'(1);
        S_U_DIVY: begin
          if (!div_done) begin
            dcnt_q <= dcnt_q - DCNT_W'(1);
          end else begin
            j_q     <= j_last ? '0 : j_q + CIDX_W'(1);
            close_q <= 1'b1;
          end
        end
        S_U_SEED: dcnt_q <= DCNT_W'(DIV_W);
        S_U_MOD: begin
          if (!div_done) begin
            dcnt_q <= dcnt_q - DCNT_W'(1);
          end
        end
        S_U_WR: begin
          j_q     <= j_last ? '0 : j_q + CIDX_W'(1);
          close_q <= 1'b1;
        end
        S_OUT: begin
          if (load_ok) begin
            j_q <= j_last ? '0 : j_q + CIDX_W'(1);
            if (j_last) begin
              cnt_q <= '0;
            end
          end
        end
        default: j_q <= j_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_START: begin
        for (int c = 0; c < MAX_CLUSTERS; c++) begin
          prev_x[c] <= '0;
          prev_y[c] <= '0;
          if (few_c) begin
            cen_x[c] <= '0;
            cen_y[c] <= '0;
          end
        end
      end
      S_INIT_WR: begin
        cen_x[j_q] <= rd_x_q;
        cen_y[j_q] <= rd_y_q;
      end
      S_DECIDE: begin
        for (int c = 0; c < MAX_CLUSTERS; c++) begin
          prev_x[c] <= cen_x[c];
          prev_y[c] <= cen_y[c];
          sum_x[c]  <= '0;
          sum_y[c]  <= '0;
          mcnt[c]   <= '0;
        end
      end
      S_A_LD: begin
        px_q <= rd_x_q;
        py_q <= rd_y_q;
      end
      S_D0: begin
        dx_q <= adx;
        dy_q <= ady;
      end
      S_D1: sqx_q <= prod;
      S_D2: sqy_q <= prod;
      S_D3: begin
        if (j_q == '0 || dist_c < bestd_q) begin
          bestd_q <= dist_c;
          best_q  <= j_q;
        end
      end
      S_ACC: begin
        sum_x[best_q] <= sum_x[best_q] + SUM_W'(px_q);
        sum_y[best_q] <= sum_y[best_q] + SUM_W'(py_q);
        mcnt[best_q]  <= mcnt[best_q] + CNT_W'(1);
      end
      S_U_SEL: begin
        dquo_q <= sum_mag;
        dneg_q <= sum_sel[SUM_W-1];
        ddiv_q <= mcnt[j_q];
        drem_q <= '0;
      end
      S_U_DIVX: begin
        if (div_done) begin
          cen_x[j_q] <= mean_c;
          dquo_q     <= sum_mag;
          dneg_q     <= sum_sel[SUM_W-1];
          drem_q     <= '0;
        end else begin
          drem_q <= dge ? dsub[CNT_W-1:0] : dtrial[CNT_W-1:0];
          dquo_q <= {dquo_q[DIV_W-2:0], dge};
        end
      end
      S_U_DIVY: begin
        if (div_done) begin
          cen_y[j_q] <= mean_c;
        end else begin
          drem_q <= dge ? dsub[CNT_W-1:0] : dtrial[CNT_W-1:0];
          dquo_q <= {dquo_q[DIV_W-2:0], dge};
        end
      end
      S_U_SEED: begin
        dquo_q <= DIV_W'(lfsr_q);
        ddiv_q <= cnt_q;
        dneg_q <= 1'b0;
        drem_q <= '0;
      end
      S_U_MOD: begin
        if (!div_done) begin
          drem_q <= dge ? dsub[CNT_W-1:0] : dtrial[CNT_W-1:0];
          dquo_q <= {dquo_q[DIV_W-2:0], dge};
        end
      end
      S_U_WR: begin
        cen_x[j_q] <= rd_x_q;
        cen_y[j_q] <= rd_y_q;
      end
      S_OUT: begin
        if (load_ok) begin
          oidx_q  <= j_q;
          ox_q    <= cen_x[j_q];
          oy_q    <= cen_y[j_q];
          oiter_q <= iter_q;
          oconv_q <= conv_q;
          olast_q <= j_last;
          ofew_q  <= few_q;
        end
      end
      default: best_q <= best_q;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign centroid_index_o  = oidx_q;
  assign centroid_x_o      = ox_q;
  assign centroid_y_o      = oy_q;
  assign iterations_used_o = oiter_q;
  assign converged_o       = oconv_q;
  assign last_result_o     = olast_q;
  assign too_few_points_o  = ofew_q;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, centroid_index_o} < k_q))
    else $error("Result index beyond the cluster count.");

  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_result_o |-> ({1'b0, centroid_index_o} == (k_q - K_W'(1))))
    else $error("Final result flag on the wrong cluster.");

  a_few_no_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_few_points_o |-> (iterations_used_o == '0) && !converged_o)
    else $error("Short data set reported iterations.");
`endif

endmodule

[test/tb_kmeans_2d_clustering_unit.sv]
// Self-checking testbench of kmeans_2d_clustering_unit, depends on kmc_pkg: directed sets
// from a table, then random sets, checked by an in-bench k-means predictor or push_too_few.
`timescale 1ns / 1ps

module tb_kmeans_2d_clustering_unit;
  import kmc_pkg::*;

  localparam int LIMIT_CYCLES = 100_000_000;
  localparam int RANDOM_ITEMS = 380;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [CIDX_W-1:0]  idx;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [ITER_W-1:0]  iters;
    logic               conv;
    logic               last;
    logic               few;
  } centroid_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    bit          last;
    bit          cfg;
    logic [31:0] k;
    logic [31:0] it;
    logic [31:0] seed;
    int          typed_k;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [COORD_W-1:0] point_x_i = '0, point_y_i = '0;
  logic last_point_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [CIDX_W-1:0] centroid_index_o;
  logic signed [COORD_W-1:0] centroid_x_o, centroid_y_o;
  logic [ITER_W-1:0] iterations_used_o;
  logic converged_o, last_result_o, too_few_points_o;

  kmeans_2d_clustering_unit u_top (.*);

  centroid_t exp_centroids[$];
  dir_row_t  dir_tab[$];
  longint    pts_x[MAX_POINTS_DEF];
  longint    pts_y[MAX_POINTS_DEF];
  int        n_pts = 0;
  logic [K_W-1:0]    cfg_k = K_RESET;
  logic [ITER_W-1:0] cfg_iter = ITER_RESET;
  logic [SEED_W-1:0] cfg_seed = SEED_RESET;
  int  typed_k = 0;
  int  fails = 0;
  int  items_sent = 0;
  int  cycles = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint abs_diff(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [66:0] sq_dist(longint px, longint py, longint cx, longint cy);
    logic [66:0] dx, dy;
    dx = 67'(abs_diff(px, cx));
    dy = 67'(abs_diff(py, cy));
    return dx * dx + dy * dy;
  endfunction

  function automatic void add_expected(centroid_t r);
    exp_centroids = {exp_centroids, r};
  endfunction

  function automatic void add_row(dir_row_t r);
    dir_tab = {dir_tab, r};
  endfunction

  function automatic void push_too_few(int k);
    centroid_t r;
    for (int j = 0; j < k; j++) begin
      r = '{idx: CIDX_W'(j), cx: '0, cy: '0, iters: '0, conv: 1'b0, last: (j == k - 1),
            few: 1'b1};
      add_expected(r);
    end
  endfunction

  function automatic void predict_clusters();
    int k, iters, best, idx;
    bit few, conv, close;
    longint cx[16], cy[16], px[16], py[16], sx[16], sy[16];
    int mc[16];
    logic [31:0] lf;
    logic [66:0] bd, d;
    centroid_t r;
    k = (cfg_k == 0) ? 1 : ((cfg_k > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(cfg_k));
    few = n_pts < k;
    conv = 1'b0;
    iters = 0;
    lf = (cfg_seed == 0) ? 32'd1 : cfg_seed;
    for (int j = 0; j < 16; j++) begin
      px[j] = 0;
      py[j] = 0;
      cx[j] = (!few && j < k) ? pts_x[j] : 0;
      cy[j] = (!few && j < k) ? pts_y[j] : 0;
    end
    if (!few) begin
      while (1) begin
        close = 1'b1;
        for (int j = 0; j < k; j++) begin
          if (abs_diff(cx[j], px[j]) >= TOL_LSB || abs_diff(cy[j], py[j]) >= TOL_LSB)
            close = 1'b0;
        end
        if (close) begin
          conv = 1'b1;
          break;
        end
        if (iters >= int'(cfg_iter)) break;
        iters++;
        for (int j = 0; j < k; j++) begin
          px[j] = cx[j];
          py[j] = cy[j];
          sx[j] = 0;
          sy[j] = 0;
          mc[j] = 0;
        end
        for (int i = 0; i < n_pts; i++) begin
          best = 0;
          bd = sq_dist(pts_x[i], pts_y[i], px[0], py[0]);
          for (int j = 1; j < k; j++) begin
            d = sq_dist(pts_x[i], pts_y[i], px[j], py[j]);
            if (d < bd) begin
              bd = d;
              best = j;
            end
          end
          sx[best] += pts_x[i];
          sy[best] += pts_y[i];
          mc[best]++;
        end
        for (int j = 0; j < k; j++) begin
          if (mc[j] != 0) begin
            cx[j] = sx[j] / mc[j];
            cy[j] = sy[j] / mc[j];
          end else begin
            lf = (lf >> 1) ^ (lf[0] ? LFSR_TAPS : 32'd0);
            idx = int'(lf % n_pts);
            cx[j] = pts_x[idx];
            cy[j] = pts_y[idx];
          end
        end
      end
    end
    for (int j = 0; j < k; j++) begin
      r = '{idx: CIDX_W'(j), cx: cx[j][31:0], cy: cy[j][31:0], iters: ITER_W'(iters),
            conv: conv, last: (j == k - 1), few: few};
      add_expected(r);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic wait_quiet();
    while (exp_centroids.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_NUM_CENTROIDS: cfg_k = data[K_W-1:0];
      REG_MAX_ITER:      cfg_iter = data[ITER_W-1:0];
      REG_SEED:          cfg_seed = data[SEED_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] k, logic [31:0] it, logic [31:0] seed);
    wait_quiet();
    reg_write(REG_NUM_CENTROIDS, k);
    reg_write(REG_MAX_ITER, it);
    reg_write(REG_SEED, seed);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, bit last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    last_point_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (n_pts < MAX_POINTS_DEF) begin
      pts_x[n_pts] = longint'($signed(x));
      pts_y[n_pts] = longint'($signed(y));
      n_pts++;
    end
    if (last) begin
      in_valid_i <= 1'b0;
      if (typed_k != 0) push_too_few(typed_k);
      else predict_clusters();
      n_pts = 0;
    end
  endtask

  function automatic logic [31:0] rand_coord(int mode, logic [31:0] center);
    case (mode)
      0: return center + $signed($urandom_range(0, 32767)) - 16384;
      1: return $urandom;
      default: return $signed($urandom_range(0, 12000)) - 6000;
    endcase
  endfunction

  task automatic random_set();
    int r, keff, n, mode, ncent;
    logic [31:0] k, it, seed;
    logic [31:0] centers_x[4], centers_y[4];
    r = $urandom_range(0, 99);
    if (r < 70) k = $urandom_range(1, 6);
    else if (r < 80) k = 0;
    else if (r < 90) k = MAX_CLUSTERS;
    else k = $urandom_range(17, 31);
    keff = (k == 0) ? 1 : ((k > MAX_CLUSTERS) ? MAX_CLUSTERS : k);
    r = $urandom_range(0, 99);
    if (r < 80 || keff > 6) it = $urandom_range(0, 12);
    else if (r < 95) it = 100;
    else it = (keff <= 3) ? 200 : 20;
    seed = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
    if ($urandom_range(0, 7) == 0) begin
      wait_quiet();
      reg_write(REG_UNUSED, $urandom);
    end
    set_config(k, it, seed);
    if (keff >= MAX_CLUSTERS) n = $urandom_range(14, 20);
    else if ($urandom_range(0, 9) == 0) n = $urandom_range(1, keff);
    else n = $urandom_range(1, 12);
    r = $urandom_range(0, 99);
    mode = (r < 70) ? 0 : ((r < 85) ? 1 : 2);
    ncent = $urandom_range(1, 4);
    for (int c = 0; c < 4; c++) begin
      centers_x[c] = $signed($urandom_range(0, 2097151)) - 1048576;
      centers_y[c] = $signed($urandom_range(0, 2097151)) - 1048576;
    end
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, ncent - 1);
      send_point(rand_coord(mode, centers_x[r]), rand_coord(mode, centers_y[r]), i == n - 1);
    end
  endtask

  always @(posedge clk_i) begin
    centroid_t e;
    int r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_centroids.size() == 0) begin
        $display("%0t: unexpected result, actual idx %0d x %h y %h", $time,
                 centroid_index_o, centroid_x_o, centroid_y_o);
        fails++;
      end else begin
        e = exp_centroids.pop_front();
        if (centroid_index_o !== e.idx || centroid_x_o !== e.cx || centroid_y_o !== e.cy ||
            iterations_used_o !== e.iters || converged_o !== e.conv ||
            last_result_o !== e.last || too_few_points_o !== e.few) begin
          $display("%0t: expected idx %0d x %h y %h it %0d conv %b last %b few %b", $time,
                   e.idx, e.cx, e.cy, e.iters, e.conv, e.last, e.few);
          $display("%0t: actual   idx %0d x %h y %h it %0d conv %b last %b few %b", $time,
                   centroid_index_o, centroid_x_o, centroid_y_o, iterations_used_o,
                   converged_o, last_result_o, too_few_points_o);
          fails++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (calm || r < 65) out_stall_i <= 1'b0;
      else begin
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        out_stall_i <= 1'b1;
      end
    end
  end

  initial begin
    dir_row_t row;
    add_row('{32'h0, 32'h0, 1, 0, 0, 0, 0, 4});
    add_row('{32'd100, -32'sd100, 0, 1, 4, 100, 1, 0});
    add_row('{32'd6553, 32'h0, 0, 0, 0, 0, 0, 0});
    add_row('{32'h0, -32'sd6553, 0, 0, 0, 0, 0, 0});
    add_row('{32'd1, 32'd1, 1, 0, 0, 0, 0, 0});
    add_row('{32'h7fffffff, 32'h80000000, 0, 1, 0, 0, 5, 0});
    add_row('{32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0, 0});
    add_row('{32'hffffffff, 32'h0, 0, 0, 0, 0, 0, 0});
    add_row('{32'h00010000, 32'hffff0000, 1, 0, 0, 0, 0, 0});
    add_row('{32'h00050000, 32'h00050000, 0, 1, 2, 5, 0, 0});
    add_row('{32'h00050000, 32'h00050000, 0, 0, 0, 0, 0, 0});
    add_row('{32'h00050000, 32'h00050000, 0, 0, 0, 0, 0, 0});
    add_row('{32'h00050000, 32'h00050000, 1, 0, 0, 0, 0, 0});
    add_row('{32'h7fffffff, 32'h7fffffff, 0, 1, 31, 65535, 32'hffffffff, 16});
    add_row('{32'h80000000, 32'h80000000, 0, 0, 0, 0, 0, 16});
    add_row('{32'h0, 32'h0, 0, 0, 0, 0, 0, 16});
    add_row('{32'h12345678, 32'h9abcdef0, 0, 0, 0, 0, 0, 16});
    add_row('{32'hdeadbeef, 32'h01234567, 1, 0, 0, 0, 0, 16});
    add_row('{32'h7fff0000, 32'h7fff0000, 0, 1, 3, 3, 32'h12345678, 0});
    add_row('{32'h80010000, 32'h80010000, 0, 0, 0, 0, 0, 0});
    add_row('{32'h7fff0000, 32'h80010000, 0, 0, 0, 0, 0, 0});
    add_row('{32'h00000000, 32'h00000000, 0, 0, 0, 0, 0, 0});
    add_row('{32'h7ffe0000, 32'h7fff0000, 1, 0, 0, 0, 0, 0});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    calm = 1'b1;
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.cfg) set_config(row.k, row.it, row.seed);
      typed_k = row.typed_k;
      send_point(row.x, row.y, row.last);
      calm = (i < 5);
    end
    typed_k = 0;

    while (items_sent < RANDOM_ITEMS) random_set();

    wait_quiet();
    if (fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
